### rtl/core/assert_macros.svh
// Assertion macros shared by the queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define BQD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// check a consequence in the cycle after an antecedent
`define BQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/bqd_pkg.sv
// Shared widths and operation codes of the bounded queue
package bqd_pkg;

  localparam int MODE_BITS = 3;
  localparam int ITEM_BITS = 32;
  localparam int LEN_BITS  = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_PREPEND = 3'd1,
    MODE_DEQUEUE = 3'd2,
    MODE_DELETE  = 3'd3,
    MODE_ITERATE = 3'd4
  } mode_t;

endpackage

### rtl/core/bqd_if.sv
// Request and response channel interfaces of the bounded queue
interface bqd_in_if import bqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  logic [ITEM_BITS-1:0] item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface bqd_out_if import bqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [ITEM_BITS-1:0] out_value;
  logic                 has_value;
  logic [LEN_BITS-1:0]  length;
  logic                 last;

  modport source (output valid, output status, output out_value, output has_value,
                  output length, output last, input ready);
  modport sink   (input valid, input status, input out_value, input has_value,
                  input length, input last, output ready);
endinterface

### rtl/core/bounded_queue_with_delete.sv
// Top level of the bounded queue with append, prepend, dequeue, delete and walk
//
// Requests arrive on req (mode, item_value); results leave on rsp (status,
// out_value, has_value, length, last). A beat moves on valid and ready high.
// One request is in work at a time; req.ready is high only while the
// sequencer is idle. Every access goes through the entry RAM, which has one
// write port and one read port and a registered read; the steps are:
//   append, prepend, failed ops : write unless full, then load the result
//   dequeue                     : read the head entry, then load its value
//   delete                      : read and compare each entry up to the match
//                                 (all of them on no match), read and write
//                                 back each entry behind it, then load
//   iterate                     : read each entry, load one beat each
// A new request is taken the cycle after the last result is loaded. The result
// sits in an output register, so a new request is taken while the last result
// of the previous one still waits. When rsp stalls, the sequencer holds
// before loading its next result beat.
// Reset empties the queue (head and count to zero) and drops any pending
// beat; the entry RAM is not cleared, since only written entries are read.
module bounded_queue_with_delete import bqd_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  bqd_in_if.sink    req,
  bqd_out_if.source rsp
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DEQ, S_SRD, S_SCMP, S_SHRD, S_SHWR, S_ITRD, S_ITOUT, S_RESP
  } state_t;

  state_t                state;
  mode_t                 op;
  logic [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      k;
  logic                  res_status;
  logic                  res_has;
  logic [VALUE_BITS-1:0] res_value;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic             full;
  logic             empty;
  logic             out_free;
  logic             load_beat;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [CNT_W-1:0] k_inc;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(h) + (CNT_W + 1)'(n);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] to_val(input logic [ITEM_BITS-1:0] x);
    logic [VALUE_BITS+ITEM_BITS-1:0] w;
    w = {{VALUE_BITS{1'b0}}, x};
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic logic [ITEM_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] x);
    logic [VALUE_BITS+ITEM_BITS-1:0] w;
    w = {{ITEM_BITS{1'b0}}, x};
    return w[ITEM_BITS-1:0];
  endfunction

  function automatic logic [LEN_BITS-1:0] to_len(input logic [CNT_W-1:0] x);
    logic [CNT_W+LEN_BITS-1:0] w;
    w = {{LEN_BITS{1'b0}}, x};
    return w[LEN_BITS-1:0];
  endfunction

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign out_free  = !rsp.valid || rsp.ready;
  assign load_beat = (state == S_ITOUT || state == S_RESP) && out_free;
  assign head_dec  = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign k_inc     = k + 1'b1;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(head, count);
    ram_wdata = val;
    ram_re    = 1'b0;
    ram_raddr = slot_of(head, k);
    unique case (state)
      S_EXEC: begin
        if (op == MODE_APPEND && !full) begin
          ram_we = 1'b1;
        end else if (op == MODE_PREPEND && !full) begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
        end else if (op == MODE_DEQUEUE && !empty) begin
          ram_re    = 1'b1;
          ram_raddr = head;
        end
      end
      S_SRD, S_ITRD: begin
        ram_re = 1'b1;
      end
      S_SHRD: begin
        ram_re    = (k_inc < count);
        ram_raddr = slot_of(head, k_inc);
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head, k);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  bqd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      k         <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (load_beat) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= mode_t'(req.mode);
            val   <= to_val(req.item_value);
            k     <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_has   <= 1'b0;
          res_value <= '0;
          unique case (op)
            MODE_APPEND: begin
              res_status <= full;
              state      <= S_RESP;
              if (!full) begin
                count <= count + 1'b1;
              end
            end
            MODE_PREPEND: begin
              res_status <= full;
              state      <= S_RESP;
              if (!full) begin
                head  <= head_dec;
                count <= count + 1'b1;
              end
            end
            MODE_DEQUEUE: begin
              res_status <= 1'b1;
              state      <= empty ? S_RESP : S_DEQ;
            end
            MODE_DELETE: begin
              res_status <= 1'b1;
              state      <= empty ? S_RESP : S_SRD;
            end
            MODE_ITERATE: begin
              res_status <= 1'b0;
              state      <= empty ? S_RESP : S_ITRD;
            end
            default: begin
              res_status <= 1'b1;
              state      <= S_RESP;
            end
          endcase
        end
        S_DEQ: begin
          res_status <= 1'b0;
          res_has    <= 1'b1;
          res_value  <= ram_rdata;
          head       <= head_inc;
          count      <= count - 1'b1;
          state      <= S_RESP;
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (ram_rdata == val) begin
            state <= S_SHRD;
          end else if (k_inc == count) begin
            state <= S_RESP;
          end else begin
            k     <= k_inc;
            state <= S_SRD;
          end
        end
        S_SHRD: begin
          if (k_inc < count) begin
            state <= S_SHWR;
          end else begin
            count      <= count - 1'b1;
            res_status <= 1'b0;
            state      <= S_RESP;
          end
        end
        S_SHWR: begin
          k     <= k_inc;
          state <= S_SHRD;
        end
        S_ITRD: begin
          state <= S_ITOUT;
        end
        S_ITOUT: begin
          if (out_free) begin
            rsp.status    <= 1'b0;
            rsp.out_value <= to_out(ram_rdata);
            rsp.has_value <= 1'b1;
            rsp.length    <= to_len(count);
            rsp.last      <= (k_inc == count);
            if (k_inc == count) begin
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_ITRD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp.status    <= res_status;
            rsp.out_value <= to_out(res_value);
            rsp.has_value <= res_has;
            rsp.length    <= to_len(count);
            rsp.last      <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BQD_ASSERT_ALWAYS(a_count_bound, count <= FULL_CNT)
  `BQD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `BQD_ASSERT_ALWAYS(a_value_means_ok, !(rsp.valid && rsp.has_value) || !rsp.status)
  `BQD_ASSERT_ALWAYS(a_no_write_idle, !(ram_we && state == S_IDLE))

endmodule

### rtl/core/bqd_ram.sv
// Generic single write port RAM with registered read
module bqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### verif/tb_bounded_queue_with_delete.sv
// Self-checking testbench for the bounded queue with append, prepend, dequeue, delete and walk
`timescale 1ns / 1ps

module tb_bounded_queue_with_delete;
  import bqd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_ITEMS  = 100;
  localparam int HOLD_AT_ITEM = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PRINT_CAP    = 40;
  localparam logic [MODE_BITS-1:0] MODE_LAST_CODE = 3'd7;

  typedef struct packed {
    logic                 status;
    logic [ITEM_BITS-1:0] out_value;
    logic                 has_value;
    logic [LEN_BITS-1:0]  length;
    logic                 last;
  } result_beat_t;

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    logic [ITEM_BITS-1:0] value;
    int                   reps;
    bit                   typed;
    result_beat_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bqd_in_if  req ();
  bqd_out_if rsp ();

  bounded_queue_with_delete #(
    .DEPTH      (QUEUE_DEPTH),
    .VALUE_BITS (ITEM_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [ITEM_BITS-1:0] model_entries[$];
  result_beat_t         fresh_beats[$];
  result_beat_t         awaited_beats[$];
  stim_row_t            directed_rows[$];

  bit           row_typed = 1'b0;
  result_beat_t row_want;
  bit           quiet_phase = 1'b0;
  int           rsp_hold_cycles = 0;
  int           cycle_count = 0;
  int           mismatch_count = 0;
  int           beats_checked = 0;
  int           requests_accepted = 0;
  int           full_rejects = 0;
  int           walks = 0;

  function automatic result_beat_t make_beat(logic st, logic [ITEM_BITS-1:0] ov, logic hv,
                                             logic lst);
    result_beat_t b;
    b.status    = st;
    b.out_value = ov;
    b.has_value = hv;
    b.length    = LEN_BITS'(model_entries.size());
    b.last      = lst;
    return b;
  endfunction

  task automatic run_queue_op(input logic [MODE_BITS-1:0] m, input logic [ITEM_BITS-1:0] v);
    logic [ITEM_BITS-1:0] popped;
    int                   hit;
    hit = -1;
    fresh_beats.delete();
    case (m)
      MODE_APPEND, MODE_PREPEND: begin
        if (model_entries.size() >= QUEUE_DEPTH) begin
          full_rejects++;
          fresh_beats.push_back(make_beat(1'b1, '0, 1'b0, 1'b1));
        end else begin
          if (m == MODE_APPEND) model_entries.push_back(v);
          else model_entries.push_front(v);
          fresh_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1));
        end
      end
      MODE_DEQUEUE: begin
        if (model_entries.size() == 0) begin
          fresh_beats.push_back(make_beat(1'b1, '0, 1'b0, 1'b1));
        end else begin
          popped = model_entries.pop_front();
          fresh_beats.push_back(make_beat(1'b0, popped, 1'b1, 1'b1));
        end
      end
      MODE_DELETE: begin
        foreach (model_entries[k]) begin
          if (hit < 0 && model_entries[k] == v) hit = k;
        end
        if (hit >= 0) begin
          model_entries.delete(hit);
          fresh_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1));
        end else begin
          fresh_beats.push_back(make_beat(1'b1, '0, 1'b0, 1'b1));
        end
      end
      MODE_ITERATE: begin
        walks++;
        if (model_entries.size() == 0) begin
          fresh_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1));
        end else begin
          foreach (model_entries[k]) begin
            fresh_beats.push_back(make_beat(1'b0, model_entries[k], 1'b1,
                                            k == model_entries.size() - 1));
          end
        end
      end
      default: begin
        fresh_beats.push_back(make_beat(1'b1, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [ITEM_BITS-1:0] got,
                                 logic [ITEM_BITS-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH at beat %0d, cycle %0d: %s got %h expected %h",
               beats_checked, cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (!rst && req.valid === 1'b1 && req.ready === 1'b1) begin
      requests_accepted++;
      run_queue_op(req.mode, req.item_value);
      if (row_typed) begin
        fresh_beats.delete();
        fresh_beats.push_back(row_want);
      end
      foreach (fresh_beats[i]) awaited_beats.push_back(fresh_beats[i]);
    end
  end

  always @(posedge clk) begin
    result_beat_t got;
    result_beat_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = '{rsp.status, rsp.out_value, rsp.has_value, rsp.length, rsp.last};
      if (awaited_beats.size() == 0) begin
        report_mismatch("beat with nothing awaited, out_value", got.out_value, '0);
      end else begin
        want = awaited_beats.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.out_value !== want.out_value)
          report_mismatch("out_value", got.out_value, want.out_value);
        if (got.has_value !== want.has_value)
          report_mismatch("has_value", got.has_value, want.has_value);
        if (got.length !== want.length)
          report_mismatch("length", got.length, want.length);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
      end
      beats_checked++;
    end
  end

  // response side: random stall bursts, plus the long hold when asked
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d beats still awaited", cycle_count,
             awaited_beats.size());
    $display("tb_bounded_queue_with_delete: FAIL");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic offer_request(input logic [MODE_BITS-1:0] m, input logic [ITEM_BITS-1:0] v);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= m;
    req.item_value <= v;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
  endtask

  function automatic stim_row_t stim_row(logic [MODE_BITS-1:0] m, logic [ITEM_BITS-1:0] v,
                                         int reps, bit typed, logic st,
                                         logic [ITEM_BITS-1:0] ov, logic hv,
                                         logic [LEN_BITS-1:0] len);
    stim_row_t r;
    r.mode  = m;
    r.value = v;
    r.reps  = reps;
    r.typed = typed;
    r.want  = '{st, ov, hv, len, 1'b1};
    return r;
  endfunction

  function automatic logic [ITEM_BITS-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return 32'hC0DE_0000 | ITEM_BITS'($urandom_range(0, 5));
      7:          return '0;
      8:          return '1;
      default:    return ITEM_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [MODE_BITS-1:0] m;
    logic [ITEM_BITS-1:0] v;
    int                   pick;
    bit                   grow;

    req.valid      = 1'b0;
    req.mode       = MODE_APPEND;
    req.item_value = '0;
    row_want       = '0;

    directed_rows.push_back(stim_row(MODE_DEQUEUE, '0, 1, 1, 1'b1, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_ITERATE, '1, 1, 1, 1'b0, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_DELETE, '0, 1, 1, 1'b1, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_LAST_CODE, '1, 1, 1, 1'b1, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_PREPEND, '1, 1, 1, 1'b0, '0, 1'b0, 5'd1));
    directed_rows.push_back(stim_row(MODE_APPEND, '0, 1, 1, 1'b0, '0, 1'b0, 5'd2));
    directed_rows.push_back(stim_row(MODE_APPEND, 32'hA5A5_A5A5, 14, 0, 1'b0, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_APPEND, 32'h5A5A_5A5A, 1, 1, 1'b1, '0, 1'b0, 5'd16));
    directed_rows.push_back(stim_row(MODE_PREPEND, 32'h5A5A_5A5A, 1, 1, 1'b1, '0, 1'b0, 5'd16));
    directed_rows.push_back(stim_row(MODE_ITERATE, '0, 1, 0, 1'b0, '0, 1'b0, 5'd0));
    directed_rows.push_back(stim_row(MODE_DELETE, '0, 1, 1, 1'b0, '0, 1'b0, 5'd15));
    directed_rows.push_back(stim_row(MODE_DELETE, 32'h1357_9BDF, 1, 1, 1'b1, '0, 1'b0, 5'd15));
    directed_rows.push_back(stim_row(MODE_DEQUEUE, '0, 1, 1, 1'b0, '1, 1'b1, 5'd14));
    directed_rows.push_back(stim_row(MODE_ITERATE, '0, 1, 0, 1'b0, '0, 1'b0, 5'd0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        row_typed = directed_rows[i].typed;
        row_want  = directed_rows[i].want;
        offer_request(directed_rows[i].mode,
                      directed_rows[i].value ^ (ITEM_BITS'(r) * 32'h0101_0101));
      end
    end
    row_typed = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      grow = ((n / 40) % 2) == 0;
      if (n == HOLD_AT_ITEM) rsp_hold_cycles = HOLD_CYCLES;
      if (n == DRAIN_AT) begin
        req.valid <= 1'b0;
        do @(negedge clk); while (awaited_beats.size() != 0);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;

      pick = $urandom_range(0, 99);
      if (grow) begin
        if (pick < 30)      m = MODE_APPEND;
        else if (pick < 55) m = MODE_PREPEND;
        else if (pick < 67) m = MODE_DEQUEUE;
        else if (pick < 80) m = MODE_DELETE;
        else if (pick < 94) m = MODE_ITERATE;
        else                m = MODE_BITS'($urandom_range(MODE_ITERATE + 1, MODE_LAST_CODE));
      end else begin
        if (pick < 15)      m = MODE_APPEND;
        else if (pick < 25) m = MODE_PREPEND;
        else if (pick < 50) m = MODE_DEQUEUE;
        else if (pick < 78) m = MODE_DELETE;
        else if (pick < 94) m = MODE_ITERATE;
        else                m = MODE_BITS'($urandom_range(MODE_ITERATE + 1, MODE_LAST_CODE));
      end

      if (m == MODE_DELETE && model_entries.size() != 0 && $urandom_range(0, 9) < 7)
        v = model_entries[$urandom_range(0, model_entries.size() - 1)];
      else
        v = pick_handle();

      offer_request(m, v);
    end

    req.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d result beats, including %0d walks",
             requests_accepted, beats_checked, walks);
    $display("%0d requests rejected on a full queue, %0d mismatches",
             full_rejects, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_bounded_queue_with_delete: PASS");
    end else begin
      $display("tb_bounded_queue_with_delete: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bqd_pkg.sv
rtl/core/bqd_if.sv
rtl/core/bqd_ram.sv
rtl/core/bounded_queue_with_delete.sv
verif/tb_bounded_queue_with_delete.sv
